/* rtl/assert_macros.svh */
// Assertion macros used by the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion sampled on clk and switched off while rst_n is low.
`define ASSERT_CLK_RST(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Concurrent assertion sampled on clk at every edge, reset included.
`define ASSERT_CLK(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* rtl/gnm_pkg.sv */
// Package with the widths, weights and record types of the glyph matcher.
`default_nettype none

package gnm_pkg;

    localparam int CODE_W      = 8;
    localparam int HOLE_W      = 4;
    localparam int ASPECT_W    = 16;
    localparam int DENS_W      = 13;
    localparam int DENS_N      = 8;
    localparam int FEAT_W      = 16;
    localparam int FEAT_N      = 9;
    localparam int SCORE_W     = 21;
    localparam int OUT_SCORE_W = 18;
    localparam int PROD_W      = 23;
    localparam int HOLE_TERM_W = 18;

    localparam int HoleWeight  = 10000;
    localparam int FeatWeight  = 100;

    localparam int S_TDATA_W   = 136;
    localparam int M_TDATA_W   = 32;

    // Request kinds carried in tuser.
    localparam logic CMD_STORE = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    // One stored record: holes and nine features, aspect first.
    typedef struct packed {
        logic [HOLE_W-1:0]            holes;
        logic [FEAT_N-1:0][FEAT_W-1:0] feat;
    } rec_t;

    // Token that travels along the row of scoring cells.
    typedef struct packed {
        logic                          act;
        logic                          hit;
        logic                          last;
        logic [CODE_W-1:0]             code;
        logic [SCORE_W-1:0]            score;
        logic [FEAT_N-1:0][FEAT_W-1:0] feat;
    } tok_t;

endpackage

`default_nettype wire

/* rtl/gnm_feat_cell.sv */
// One scoring cell: adds the weighted term of one feature and passes the token on.
`default_nettype none

module gnm_feat_cell #(
    parameter int IDX       = 0,
    parameter int FRAC_BITS = 12
) (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic [gnm_pkg::FEAT_W-1:0]  qry_feat,
    input  wire gnm_pkg::tok_t               tok_in,
    output gnm_pkg::tok_t                    tok_out
);

    gnm_pkg::tok_t                    tok_reg;
    gnm_pkg::tok_t                    tok_next;
    logic [gnm_pkg::FEAT_W-1:0]       stored;
    logic [gnm_pkg::FEAT_W-1:0]       diff;
    logic [gnm_pkg::PROD_W-1:0]       prod;

    // Absolute difference, scaled by the feature weight and floored.
    always_comb begin
        stored = tok_in.feat[IDX];
        diff   = (stored > qry_feat) ? (stored - qry_feat) : (qry_feat - stored);
        prod   = gnm_pkg::PROD_W'(diff) * gnm_pkg::PROD_W'(gnm_pkg::FeatWeight);
        tok_next       = tok_in;
        tok_next.score = tok_in.score + gnm_pkg::SCORE_W'(prod >> FRAC_BITS);
    end

    // Control bits of the token.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tok_reg.act  <= 1'b0;
            tok_reg.hit  <= 1'b0;
            tok_reg.last <= 1'b0;
        end else begin
            tok_reg.act  <= tok_next.act;
            tok_reg.hit  <= tok_next.hit;
            tok_reg.last <= tok_next.last;
        end
    end

    // Payload of the token.
    always_ff @(posedge aclk) begin
        tok_reg.code  <= tok_next.code;
        tok_reg.score <= tok_next.score;
        tok_reg.feat  <= tok_next.feat;
    end

    assign tok_out = tok_reg;

endmodule

`default_nettype wire

/* rtl/glyph_nearest_match.sv */
// Top level of the nearest-match glyph classifier: record memory, scan and minimum.
//
// A store request (tuser = 0) writes the record for its code and gives no
// result; a code at or beyond CODE_COUNT is dropped. A query request (tuser = 1)
// reads the record memory once per code, one address a cycle, and each record
// runs through a row of nine scoring cells, one per feature, behind a hole
// stage; the lowest score wins, a tie keeps the lower code. The scan goes
// through the single read port of the record memory, and no further request
// is taken until the result is in the output register. A result waiting in
// the output register does not hold off store requests. Valid bits are
// cleared by reset at once, so there is no clearing pass.
`default_nettype none

module glyph_nearest_match #(
    parameter int CODE_COUNT = 256,
    parameter int FRAC_BITS  = 12
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    // code[7:0], hole_count[11:8], aspect[27:12], dens_total[40:28],
    // dens_border[53:41], dens_q1[66:54], dens_q2[79:67], dens_q3[92:80],
    // dens_q4[105:93], dens_mid1[118:106], dens_mid2[131:119], zeros above
    input  wire logic [gnm_pkg::S_TDATA_W-1:0]   s_tdata,
    // cmd[0]
    input  wire logic                            s_tuser,
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    // best_code[7:0], best_score[25:8], found[26], zeros above
    output logic [gnm_pkg::M_TDATA_W-1:0]        m_tdata
);

    localparam int IDX_W = (CODE_COUNT > 1) ? $clog2(CODE_COUNT) : 1;

    typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_DRAIN, ST_FIN} state_t;

    state_t                               state_reg;
    logic                                 accept;
    logic                                 wr_en;
    gnm_pkg::rec_t                        in_rec;
    logic [gnm_pkg::CODE_W-1:0]           in_code;

    gnm_pkg::rec_t                        mem [CODE_COUNT];
    logic [CODE_COUNT-1:0]                valid_reg;

    logic [IDX_W-1:0]                     addr_reg;
    logic                                 rd_act_reg;
    logic                                 rd_last_reg;
    logic                                 rd_hit_reg;
    logic [IDX_W-1:0]                     rd_addr_reg;
    gnm_pkg::rec_t                        rd_data_reg;

    gnm_pkg::rec_t                        qry_reg;
    gnm_pkg::tok_t                        tok0_reg;
    gnm_pkg::tok_t                        tok [gnm_pkg::FEAT_N+1];
    logic [gnm_pkg::HOLE_W-1:0]           hole_diff;
    logic [gnm_pkg::HOLE_TERM_W-1:0]      hole_term;

    logic                                 found_reg;
    logic [gnm_pkg::CODE_W-1:0]           best_code_reg;
    logic [gnm_pkg::SCORE_W-1:0]          best_score_reg;
    logic                                 take_best;
    gnm_pkg::tok_t                        tail;

    logic                                 m_tvalid_reg;
    logic [gnm_pkg::M_TDATA_W-1:0]        m_tdata_reg;

    // Unpack the request into a record.
    always_comb begin
        in_code       = s_tdata[7:0];
        in_rec.holes  = s_tdata[11:8];
        in_rec.feat[0] = s_tdata[27:12];
        for (int k = 0; k < gnm_pkg::DENS_N; k++) begin
            in_rec.feat[k+1] = gnm_pkg::FEAT_W'(s_tdata[28 + k*gnm_pkg::DENS_W +: gnm_pkg::DENS_W]);
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign wr_en    = accept && (s_tuser == gnm_pkg::CMD_STORE) &&
                      ({1'b0, in_code} < 9'(CODE_COUNT));

    // Record memory: one write port, one registered read port.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[in_code[IDX_W-1:0]] <= in_rec;
        end
        rd_data_reg <= mem[addr_reg];
        rd_addr_reg <= addr_reg;
        rd_hit_reg  <= valid_reg[addr_reg];
    end

    // Valid bits, cleared by reset.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (wr_en) begin
            valid_reg[in_code[IDX_W-1:0]] <= 1'b1;
        end
    end

    // Hole term and entry into the row of cells.
    always_comb begin
        hole_diff = (rd_data_reg.holes > qry_reg.holes) ? (rd_data_reg.holes - qry_reg.holes)
                                                       : (qry_reg.holes - rd_data_reg.holes);
        hole_term = gnm_pkg::HOLE_TERM_W'(hole_diff) *
                    gnm_pkg::HOLE_TERM_W'(gnm_pkg::HoleWeight);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tok0_reg.act  <= 1'b0;
            tok0_reg.hit  <= 1'b0;
            tok0_reg.last <= 1'b0;
        end else begin
            tok0_reg.act  <= rd_act_reg;
            tok0_reg.hit  <= rd_act_reg && rd_hit_reg;
            tok0_reg.last <= rd_act_reg && rd_last_reg;
        end
    end

    always_ff @(posedge aclk) begin
        tok0_reg.code  <= gnm_pkg::CODE_W'(rd_addr_reg);
        tok0_reg.score <= gnm_pkg::SCORE_W'(hole_term);
        tok0_reg.feat  <= rd_data_reg.feat;
    end

    assign tok[0] = tok0_reg;

    // Row of scoring cells, one per feature.
    for (genvar i = 0; i < gnm_pkg::FEAT_N; i++) begin : g_cell
        gnm_feat_cell #(
            .IDX       (i),
            .FRAC_BITS (FRAC_BITS)
        ) u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .qry_feat (qry_reg.feat[i]),
            .tok_in   (tok[i]),
            .tok_out  (tok[i+1])
        );
    end

    assign tail      = tok[gnm_pkg::FEAT_N];
    assign take_best = tail.act && tail.hit && (!found_reg || (tail.score < best_score_reg));

    // Query features held for the whole scan.
    always_ff @(posedge aclk) begin
        if (accept && (s_tuser == gnm_pkg::CMD_QUERY)) begin
            qry_reg <= in_rec;
        end
    end

    // Running minimum payload.
    always_ff @(posedge aclk) begin
        if (accept && (s_tuser == gnm_pkg::CMD_QUERY)) begin
            best_code_reg  <= '0;
            best_score_reg <= '0;
        end else if (take_best) begin
            best_code_reg  <= tail.code;
            best_score_reg <= tail.score;
        end
    end

    // Result payload.
    always_ff @(posedge aclk) begin
        if ((state_reg == ST_FIN) && (!m_tvalid_reg || m_tready)) begin
            m_tdata_reg <= {5'b0, found_reg,
                            best_score_reg[gnm_pkg::OUT_SCORE_W-1:0], best_code_reg};
        end
    end

    // Sequencer: scan, drain of the cell row, and handover of the result.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            addr_reg     <= '0;
            rd_act_reg   <= 1'b0;
            rd_last_reg  <= 1'b0;
            found_reg    <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            rd_act_reg  <= 1'b0;
            rd_last_reg <= 1'b0;
            if (m_tvalid_reg && m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            if (take_best) begin
                found_reg <= 1'b1;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    addr_reg <= '0;
                    if (accept && (s_tuser == gnm_pkg::CMD_QUERY)) begin
                        found_reg <= 1'b0;
                        state_reg <= ST_SCAN;
                    end
                end
                ST_SCAN: begin
                    rd_act_reg <= 1'b1;
                    if (addr_reg == IDX_W'(CODE_COUNT - 1)) begin
                        rd_last_reg <= 1'b1;
                        state_reg   <= ST_DRAIN;
                    end else begin
                        addr_reg <= addr_reg + 1'b1;
                    end
                end
                ST_DRAIN: begin
                    if (tail.act && tail.last) begin
                        state_reg <= ST_FIN;
                    end
                end
                ST_FIN: begin
                    if (!m_tvalid_reg || m_tready) begin
                        m_tvalid_reg <= 1'b1;
                        state_reg    <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

`default_nettype wire

/* rtl/gnm_checker.sv */
// Port-level checker for the glyph matcher and its bind to the top level.
`default_nettype none
`include "assert_macros.svh"

module gnm_checker (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_tvalid,
    input  wire logic                          s_tready,
    input  wire logic                          s_tuser,
    input  wire logic                          m_tvalid,
    input  wire logic                          m_tready,
    input  wire logic [gnm_pkg::M_TDATA_W-1:0] m_tdata
);

    // A stalled result keeps its data.
    `ASSERT_CLK_RST(a_out_hold, aclk, aresetn, (m_tvalid && !m_tready) |=> $stable(m_tdata), "result changed while stalled")

    // An empty table reports code and score as zero.
    `ASSERT_CLK_RST(a_empty_zero, aclk, aresetn, (m_tvalid && !m_tdata[26]) |-> (m_tdata[25:0] == 26'd0), "empty result not zero")

    // An accepted query blocks further requests in the next cycle.
    `ASSERT_CLK_RST(a_query_busy, aclk, aresetn, (s_tvalid && s_tready && s_tuser) |=> !s_tready, "request taken during scan")

    // Padding bits above the result fields stay low.
    `ASSERT_CLK(a_pad_zero, aclk, (!aresetn || !m_tvalid || (m_tdata[31:27] == 5'd0)), "result padding not zero")

endmodule

bind glyph_nearest_match gnm_checker u_gnm_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire
